// File: rtl/core/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

    localparam int WORD_BITS    = 32;
    localparam int LEN_BITS     = 20;
    localparam int BYTE_W       = 8;
    localparam int SKIP_W       = 5;
    localparam int CNT_W        = $clog2(WORD_BITS + 1);
    localparam int HDR_W        = $clog2(LEN_BITS + 1);
    localparam int FILL_W       = 3;
    localparam int NBITS_W      = 4;
    localparam int MAX_RESULTS  = 6;
    localparam int RES_CNT_W    = 3;
    localparam int M_TDATA_W    = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [SKIP_W-1:0] SKIP_RESET = 5'd8;

    // register index codes, taken from paddr[2]
    localparam logic CFG_IDX_SKIP = 1'b0;

    typedef struct packed {
        logic                in_payload;
        logic [LEN_BITS-1:0] length;
        logic [HDR_W-1:0]    hdr_cnt;
        logic [LEN_BITS-1:0] left;
        logic [BYTE_W-1:0]   partial;
        logic [FILL_W-1:0]   fill;
        logic [SKIP_W-1:0]   skip;
    } frame_st_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [NBITS_W-1:0] byte_bits;
        logic               frame_end;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
        logic    last;
    } out_push_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_FLUSH
    } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/core/mfd_step.sv
`default_nettype none

// One shift-and-extract step: consumes bits from the top of the word up to
// the next event (skip done, length done, byte boundary or frame end).
module mfd_step
    import mfd_pkg::*;
(
    input  frame_st_t            st,
    input  logic [WORD_BITS-1:0] word,
    input  logic [CNT_W-1:0]     rem,
    output frame_st_t            st_next,
    output logic [CNT_W-1:0]     take,
    output logic                 res_valid,
    output result_t              res
);

    logic [CNT_W-1:0]    skip_ext;
    logic [CNT_W-1:0]    hdr_need;
    logic [CNT_W-1:0]    room;
    logic [CNT_W-1:0]    lim;
    logic [LEN_BITS-1:0] chunk_len;
    logic [LEN_BITS-1:0] len_sh;
    logic [HDR_W-1:0]    hdr_sum;
    logic [BYTE_W-1:0]   chunk_byte;
    logic [BYTE_W-1:0]   part_sh;
    logic [NBITS_W-1:0]  fill_sum;
    logic [LEN_BITS-1:0] left_next;

    assign skip_ext = CNT_W'(st.skip);
    assign hdr_need = CNT_W'(LEN_BITS) - CNT_W'(st.hdr_cnt);
    assign room     = CNT_W'(BYTE_W) - CNT_W'(st.fill);

    always_comb begin
        st_next    = st;
        take       = '0;
        res_valid  = 1'b0;
        res        = '0;
        lim        = '0;
        chunk_len  = '0;
        len_sh     = '0;
        hdr_sum    = '0;
        chunk_byte = '0;
        part_sh    = '0;
        fill_sum   = '0;
        left_next  = '0;
        if (st.skip != '0) begin
            take         = (skip_ext < rem) ? skip_ext : rem;
            st_next.skip = st.skip - SKIP_W'(take);
        end else if (!st.in_payload) begin
            take      = (hdr_need < rem) ? hdr_need : rem;
            chunk_len = word[WORD_BITS-1 -: LEN_BITS] >> (CNT_W'(LEN_BITS) - take);
            len_sh    = (st.length << take) | chunk_len;
            hdr_sum   = st.hdr_cnt + HDR_W'(take);
            st_next.length  = len_sh;
            st_next.hdr_cnt = hdr_sum;
            if (hdr_sum == HDR_W'(LEN_BITS)) begin
                st_next.hdr_cnt = '0;
                if (len_sh == '0) begin
                    // empty frame marker
                    res_valid     = 1'b1;
                    res.frame_end = 1'b1;
                end else begin
                    st_next.in_payload = 1'b1;
                    st_next.left       = len_sh;
                    st_next.partial    = '0;
                    st_next.fill       = '0;
                end
            end
        end else begin
            lim        = (room < rem) ? room : rem;
            take       = (st.left < LEN_BITS'(lim)) ? CNT_W'(st.left) : lim;
            chunk_byte = word[WORD_BITS-1 -: BYTE_W] >> (CNT_W'(BYTE_W) - take);
            part_sh    = (st.partial << take) | chunk_byte;
            fill_sum   = NBITS_W'(st.fill) + NBITS_W'(take);
            left_next  = st.left - LEN_BITS'(take);
            if (left_next == '0) begin
                res_valid          = 1'b1;
                res.frame_byte     = part_sh << (NBITS_W'(BYTE_W) - fill_sum);
                res.byte_bits      = fill_sum;
                res.frame_end      = 1'b1;
                st_next.in_payload = 1'b0;
                st_next.length     = '0;
                st_next.left       = '0;
                st_next.partial    = '0;
                st_next.fill       = '0;
            end else if (fill_sum == NBITS_W'(BYTE_W)) begin
                res_valid       = 1'b1;
                res.frame_byte  = part_sh;
                res.byte_bits   = fill_sum;
                st_next.left    = left_next;
                st_next.partial = '0;
                st_next.fill    = '0;
            end else begin
                st_next.left    = left_next;
                st_next.partial = part_sh;
                st_next.fill    = fill_sum[FILL_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mfd_outreg.sv
`default_nettype none

module mfd_outreg
    import mfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  out_push_t                 push,
    output logic                      out_free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    logic    last_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (push.valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            data_reg <= push.res;
            last_reg <= push.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - NBITS_W - BYTE_W){1'b0}},
                       data_reg.byte_bits, data_reg.frame_byte};
    assign m_tuser  = data_reg.frame_end;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/mfd_seq.sv
`default_nettype none

// Word sequencer: holds the word and frame state, runs the step unit until
// the word is used up, and keeps one result back so the last one of the
// word can be tagged.
module mfd_seq
    import mfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [WORD_BITS-1:0] s_word,
    input  wire logic                 s_restart,
    input  wire logic [SKIP_W-1:0]    skip_cfg,
    output frame_st_t                 st_cur,
    output logic [WORD_BITS-1:0]      word_cur,
    output logic [CNT_W-1:0]          rem_cur,
    input  frame_st_t                 step_st,
    input  wire logic [CNT_W-1:0]     step_take,
    input  wire logic                 step_res_valid,
    input  result_t                   step_res,
    input  wire logic                 out_free,
    output out_push_t                 push
);

    seq_state_t           state_reg, state_next;
    frame_st_t            st_reg, st_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              pend_reg, pend_next;
    logic                 keep;
    logic                 stall;

    assign st_cur   = st_reg;
    assign word_cur = word_reg;
    assign rem_cur  = rem_reg;

    // results past the cap are dropped
    assign keep  = step_res_valid && (cnt_reg != RES_CNT_W'(MAX_RESULTS));
    assign stall = keep && pend_valid_reg && !out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_IDLE;
            st_reg         <= '{skip: SKIP_RESET, default: '0};
            rem_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            st_reg         <= st_next;
            rem_reg        <= rem_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        pend_reg <= pend_next;
    end

    always_comb begin
        state_next      = state_reg;
        st_next         = st_reg;
        word_next       = word_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = '0;
        s_ready         = 1'b0;
        unique case (state_reg)
            SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    word_next  = s_word;
                    rem_next   = CNT_W'(WORD_BITS);
                    cnt_next   = '0;
                    state_next = SEQ_RUN;
                    if (s_restart) begin
                        st_next      = '0;
                        st_next.skip = skip_cfg;
                    end
                end
            end
            SEQ_RUN: begin
                if (rem_reg == '0) begin
                    state_next = SEQ_FLUSH;
                end else if (!stall) begin
                    st_next   = step_st;
                    word_next = word_reg << step_take;
                    rem_next  = rem_reg - step_take;
                    if (keep) begin
                        cnt_next        = cnt_reg + 1'b1;
                        pend_next       = step_res;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg) begin
                            push.valid = 1'b1;
                            push.res   = pend_reg;
                            push.last  = 1'b0;
                        end
                    end
                end
            end
            SEQ_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = SEQ_IDLE;
                end else if (out_free) begin
                    push.valid      = 1'b1;
                    push.res        = pend_reg;
                    push.last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/musepack_frame_deframer_core.sv
`default_nettype none

// Channel   Dir  Ports             Payload
// s_*       in   tvalid/tready     tdata[31:0] stream_word, tuser restart
// m_*       out  tvalid/tready     tdata[7:0] frame_byte, [11:8] byte_bits;
//                                  tuser frame_end, tlast run_last
// apb       in   psel/penable/...  start_skip_bits at address 0
//
// A word is accepted in SEQ_IDLE; in SEQ_RUN the shared shift/extract unit then takes
// one step per event in it (end of skip, end of length, each byte or frame end) and
// at most 6 results per word are kept; SEQ_RUN sees the word used up and SEQ_FLUSH
// sends the held result. s_tready is low while a word is in work. One result is
// held back so the last of a word can be tagged; a step that yields a result,
// and the flush, wait while that one is pending and the m_* beat is held.
// aresetn is synchronous, active low; start_skip_bits resets to 8.
module musepack_frame_deframer_core
    import mfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [WORD_BITS-1:0]  s_tdata,   // [31:0] stream_word
    input  wire logic                  s_tuser,   // restart
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [7:0] frame_byte, [11:8] byte_bits
    output logic                       m_tuser,   // frame_end
    output logic                       m_tlast,   // run_last
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [SKIP_W-1:0]    skip_cfg_reg;
    logic                 cfg_idx;
    frame_st_t            st_cur;
    logic [WORD_BITS-1:0] word_cur;
    logic [CNT_W-1:0]     rem_cur;
    frame_st_t            step_st;
    logic [CNT_W-1:0]     step_take;
    logic                 step_res_valid;
    result_t              step_res;
    logic                 out_free;
    out_push_t            push;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_cfg_reg <= SKIP_RESET;
        end else if (psel && penable && pwrite && pready && (cfg_idx == CFG_IDX_SKIP)) begin
            skip_cfg_reg <= pwdata[SKIP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            CFG_IDX_SKIP: prdata = APB_DATA_W'(skip_cfg_reg);
            default:      prdata = '0;
        endcase
    end

    mfd_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .s_word         (s_tdata),
        .s_restart      (s_tuser),
        .skip_cfg       (skip_cfg_reg),
        .st_cur         (st_cur),
        .word_cur       (word_cur),
        .rem_cur        (rem_cur),
        .step_st        (step_st),
        .step_take      (step_take),
        .step_res_valid (step_res_valid),
        .step_res       (step_res),
        .out_free       (out_free),
        .push           (push)
    );

    mfd_step u_step (
        .st        (st_cur),
        .word      (word_cur),
        .rem       (rem_cur),
        .st_next   (step_st),
        .take      (step_take),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    mfd_outreg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/mfd_checker.sv
`default_nettype none

module mfd_checker
    import mfd_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser,
    input wire logic                  m_tlast
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:8] <= 4'd8)
        else $error("byte_bits above 8");

    // empty-frame marker carries a zero byte and closes the frame
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[11:8] == 4'd0) |-> m_tuser && (m_tdata[7:0] == 8'd0))
        else $error("bad empty-frame marker");

    // only the last byte of a frame may be partial
    a_partial_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[11:8] != 4'd8) |-> m_tuser)
        else $error("partial byte not at frame end");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind musepack_frame_deframer_core mfd_checker u_mfd_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mfd_pkg::*;

    localparam int LIMIT_NS     = 10_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 40;
    localparam logic [APB_ADDR_W-1:0] SKIP_ADDR = {CFG_IDX_SKIP, 2'b00};

    typedef struct packed {
        logic [BYTE_W-1:0]  fbyte;
        logic [NBITS_W-1:0] nbits;
        logic               fend;
        logic               rlast;
    } deframed_beat_t;

    typedef enum {PAY_ZERO, PAY_ONES, PAY_RAND} payload_fill_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [WORD_BITS-1:0]  s_tdata;    // [31:0] stream_word
    logic                  s_tuser;    // restart
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // [7:0] frame_byte, [11:8] byte_bits
    logic                  m_tuser;    // frame_end
    logic                  m_tlast;    // run_last
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // deframer state as the testbench tracks it
    logic [SKIP_W-1:0]   skip_reg;
    logic [SKIP_W-1:0]   skip_left;
    logic                pl_active;
    logic [LEN_BITS-1:0] len_acc;
    logic [LEN_BITS-1:0] bits_left;
    logic [HDR_W-1:0]    hdr_cnt;
    logic [BYTE_W-1:0]   part_byte;

    deframed_beat_t pending_bytes[$];
    bit             stream_bits[$];

    int err_cnt    = 0;
    int words_sent = 0;
    int beats_seen = 0;
    int hold_len   = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;

    musepack_frame_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", what, want, got, $time);
    endtask

    task automatic clear_frame_state();
        pl_active = 1'b0;
        len_acc   = '0;
        bits_left = '0;
        hdr_cnt   = '0;
        part_byte = '0;
    endtask

    // Walks the word bit by bit, MSB first, and queues the bytes it closes.
    task automatic deframe_word(input logic [WORD_BITS-1:0] w, input logic rs);
        deframed_beat_t found[MAX_RESULTS];
        int             n;
        int             i;
        logic           b;
        logic [LEN_BITS-1:0] done;
        logic [3:0]     nb;
        n = 0;
        if (rs) begin
            clear_frame_state();
            skip_left = skip_reg;
        end
        for (i = WORD_BITS - 1; i >= 0; i--) begin
            b = w[i];
            if (skip_left != 0) begin
                skip_left--;
            end else if (!pl_active) begin
                len_acc = {len_acc[LEN_BITS-2:0], b};
                hdr_cnt++;
                if (hdr_cnt == LEN_BITS) begin
                    hdr_cnt = '0;
                    if (len_acc == 0) begin
                        if (n < MAX_RESULTS) found[n] = '{8'h00, 4'd0, 1'b1, 1'b0};
                        n++;
                    end else begin
                        pl_active = 1'b1;
                        bits_left = len_acc;
                        part_byte = '0;
                    end
                end
            end else begin
                part_byte = {part_byte[BYTE_W-2:0], b};
                bits_left--;
                done = len_acc - bits_left;
                if (bits_left == 0) begin
                    // last byte of the frame, left-aligned when short
                    nb = (done[2:0] != 0) ? {1'b0, done[2:0]} : 4'd8;
                    if (n < MAX_RESULTS)
                        found[n] = '{BYTE_W'(part_byte << (4'd8 - nb)), nb, 1'b1, 1'b0};
                    n++;
                    pl_active = 1'b0;
                    len_acc   = '0;
                    part_byte = '0;
                end else if (done[2:0] == 0) begin
                    if (n < MAX_RESULTS) found[n] = '{part_byte, 4'd8, 1'b0, 1'b0};
                    n++;
                    part_byte = '0;
                end
            end
        end
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        for (i = 0; i < n; i++) begin
            found[i].rlast = (i == n - 1);
            pending_bytes.push_back(found[i]);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_word(input logic [WORD_BITS-1:0] w, input logic rs);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= rs;
        do @(posedge aclk); while (!s_tready);
        deframe_word(w, rs);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic push_bits(input logic [31:0] v, input int count);
        int i;
        for (i = count - 1; i >= 0; i--) stream_bits.push_back(v[i]);
    endtask

    task automatic add_junk(input int count);
        repeat (count) stream_bits.push_back(1'($urandom));
    endtask

    task automatic add_frame(input int len, input payload_fill_t fill);
        push_bits(len, LEN_BITS);
        repeat (len) begin
            case (fill)
                PAY_ZERO: stream_bits.push_back(1'b0);
                PAY_ONES: stream_bits.push_back(1'b1);
                default:  stream_bits.push_back(1'($urandom));
            endcase
        end
    endtask

    // Packs the queued bits into words, first bit at the MSB; pads with noise.
    task automatic send_stream(input logic rs_first);
        logic [WORD_BITS-1:0] w;
        logic                 rs;
        int                   i;
        rs = rs_first;
        while (stream_bits.size() != 0) begin
            for (i = WORD_BITS - 1; i >= 0; i--)
                w[i] = (stream_bits.size() != 0) ? stream_bits.pop_front() : 1'($urandom);
            send_word(w, rs);
            rs = 1'b0;
        end
    endtask

    function automatic int rand_frame_len();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 75) return $urandom_range(1, 24);
        if (r < 95) return $urandom_range(25, 120);
        return $urandom_range(121, 600);
    endfunction

    task automatic random_stream();
        int keep;
        add_junk(int'(skip_reg));
        repeat ($urandom_range(1, 6)) add_frame(rand_frame_len(), PAY_RAND);
        // now and then cut the stream short in the middle of something
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(1, stream_bits.size());
            while (stream_bits.size() > keep) void'(stream_bits.pop_back());
        end
        send_stream(1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_skip(input logic [SKIP_W-1:0] v);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, SKIP_ADDR, APB_DATA_W'(v), rd);
        skip_reg = v;
        @(negedge aclk);
        apb_access(1'b0, SKIP_ADDR, '0, rd);
        if (rd != APB_DATA_W'(v)) report_mismatch("start_skip_bits readback", 32'(v), rd);
    endtask

    task automatic test_reset_defaults();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, SKIP_ADDR, '0, rd);
        if (rd != APB_DATA_W'(SKIP_RESET)) report_mismatch("start_skip_bits at reset",
                                                            32'(SKIP_RESET), rd);
        // no restart: the skip after reset must already be in force
        add_junk(int'(SKIP_RESET));
        add_frame(0, PAY_ZERO);
        add_frame(8, PAY_ONES);
        add_frame(1, PAY_ONES);
        add_frame(12, PAY_RAND);
        send_stream(1'b0);
        drain();
    endtask

    task automatic test_word_extremes();
        send_word('0, 1'b1);
        send_word('1, 1'b0);
        send_word('1, 1'b1);    // restart in the middle of a long frame
        send_word('0, 1'b0);
        drain();
    endtask

    task automatic test_frame_shapes();
        add_junk(int'(skip_reg));
        add_frame(7, PAY_RAND);
        add_frame(9, PAY_RAND);
        add_frame(16, PAY_ONES);
        add_frame(15, PAY_ZERO);
        add_frame(0, PAY_ZERO);
        add_frame(0, PAY_ZERO);
        add_frame(33, PAY_RAND);
        add_frame(5, PAY_ONES);
        send_stream(1'b1);
        drain();
    endtask

    task automatic test_skip_extremes();
        set_skip('0);
        // new value waits for a restart
        send_word($urandom, 1'b0);
        add_frame(3, PAY_ONES);
        add_frame(24, PAY_RAND);
        send_stream(1'b1);
        drain();
        set_skip('1);
        add_junk(31);
        add_frame(8, PAY_RAND);
        add_frame(0, PAY_ZERO);
        add_frame(11, PAY_RAND);
        send_stream(1'b1);
        drain();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int nwords);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        set_skip(SKIP_W'($urandom_range(31)));
        target = words_sent + nwords;
        while (words_sent < target) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 3)) send_word($urandom, $urandom_range(7) == 0);
            end else begin
                random_stream();
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_len  = HOLD_CYCLES;
        add_junk(int'(skip_reg));
        repeat (12) add_frame($urandom_range(40, 64), PAY_RAND);
        send_stream(1'b1);
        drain();
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len != 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_len = 0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_beat
        deframed_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (pending_bytes.size() == 0) begin
                report_mismatch("beat with nothing pending", 0, 32'(m_tdata));
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata[7:0] != want.fbyte)
                    report_mismatch("frame_byte", 32'(want.fbyte), 32'(m_tdata[7:0]));
                if (m_tdata[11:8] != want.nbits)
                    report_mismatch("byte_bits", 32'(want.nbits), 32'(m_tdata[11:8]));
                if (m_tuser != want.fend)
                    report_mismatch("frame_end", 32'(want.fend), 32'(m_tuser));
                if (m_tlast != want.rlast)
                    report_mismatch("run_last", 32'(want.rlast), 32'(m_tlast));
            end
        end
    end

    initial begin
        #LIMIT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        skip_reg = SKIP_RESET;
        clear_frame_state();
        skip_left = skip_reg;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_word_extremes();
        test_frame_shapes();
        test_skip_extremes();
        test_random_traffic(0, 0, 110);
        test_random_traffic(85, 0, 110);
        test_random_traffic(0, 85, 110);
        test_random_traffic(35, 35, 110);
        test_backpressure();

        $display("covered %0d stream words and %0d result beats", words_sent, beats_seen);
        $display("skips 0 to 31, restarts mid-frame, four stall mixes, one long output hold");
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
